/* rtl/k1bf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// k1bf_pkg
// Shared types and constants of the KEY1 Blowfish-style cipher engine.
// ----------------------------------------------------------------------------
package k1bf_pkg;

    localparam int unsigned TableWords = 1042;
    localparam int unsigned RoundKeys  = 18;
    localparam logic [10:0] SboxBase   = 11'h012;
    localparam logic [10:0] LastPair   = 11'h410;
    localparam logic [4:0]  LastRoundKey = 5'h11;

    localparam logic [1:0] MODE_LOAD     = 2'd0;
    localparam logic [1:0] MODE_ENCRYPT  = 2'd1;
    localparam logic [1:0] MODE_DECRYPT  = 2'd2;
    localparam logic [1:0] MODE_SCHEDULE = 2'd3;

    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_CAPTURE = 4'd1;
    localparam logic [3:0] OP_LOAD    = 4'd2;
    localparam logic [3:0] OP_INIT_KC = 4'd3;
    localparam logic [3:0] OP_INIT    = 4'd4;
    localparam logic [3:0] OP_ROUND_A = 4'd5;
    localparam logic [3:0] OP_ROUND_B = 4'd6;
    localparam logic [3:0] OP_FINISH  = 4'd7;
    localparam logic [3:0] OP_MIX     = 4'd8;
    localparam logic [3:0] OP_CLR_T   = 4'd9;
    localparam logic [3:0] OP_WR_HI   = 4'd10;
    localparam logic [3:0] OP_WR_LO   = 4'd11;
    localparam logic [3:0] OP_SHIFT   = 4'd12;
    localparam logic [3:0] OP_OUTLD   = 4'd13;

    localparam logic [1:0] JOB_BLOCK = 2'd0;
    localparam logic [1:0] JOB_KC12  = 2'd1;
    localparam logic [1:0] JOB_KC01  = 2'd2;
    localparam logic [1:0] JOB_T     = 2'd3;

    typedef struct packed {
        logic [3:0]  op;
        logic [1:0]  job;
        logic        dec;
        logic [4:0]  idx;
        logic [1:0]  kc_sel;
        logic [10:0] addr;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] level;
        logic [1:0] key_mod;
    } t_status;

endpackage
`default_nettype wire

/* rtl/k1bf_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// k1bf_datapath
// Key table storage, round datapath and keycode registers.
// ----------------------------------------------------------------------------
module k1bf_datapath (
    input  wire logic               i_clk,
    input  wire k1bf_pkg::t_cmd     i_cmd,
    input  wire logic [1:0]         i_mode,
    input  wire logic [10:0]        i_table_index,
    input  wire logic [31:0]        i_table_word,
    input  wire logic [31:0]        i_block_low,
    input  wire logic [31:0]        i_block_high,
    input  wire logic [31:0]        i_id_code,
    input  wire logic [1:0]         i_level,
    input  wire logic [1:0]         i_key_mod,
    output k1bf_pkg::t_status       o_status,
    output logic [31:0]             o_out_low,
    output logic [31:0]             o_out_high
);

    logic [31:0] r_pkey [k1bf_pkg::RoundKeys];
    logic [31:0] r_sbox [4][256];
    logic [31:0] r_sd   [4];

    logic [1:0]  r_mode, r_level, r_key_mod;
    logic [10:0] r_idx;
    logic [31:0] r_word, r_blo, r_bhi, r_id;
    logic [31:0] r_x, r_y, r_z, r_kc0, r_kc1, r_kc2, r_tl, r_th;
    logic [31:0] r_rlo, r_rhi, r_olo, r_ohi;

    logic [31:0] p_rd, z, f, kc_w, fin_lo, fin_hi, wd;
    logic [10:0] wa, s_off;
    logic        we;
    logic [7:0]  sa [4];

    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    always_comb begin
        p_rd   = r_pkey[i_cmd.idx];
        z      = p_rd ^ r_x;
        sa[0]  = z[31:24];
        sa[1]  = z[23:16];
        sa[2]  = z[15:8];
        sa[3]  = z[7:0];
        f      = ((r_sd[0] + r_sd[1]) ^ r_sd[2]) + r_sd[3];
        fin_lo = r_x ^ (i_cmd.dec ? r_pkey[1] : r_pkey[16]);
        fin_hi = r_y ^ (i_cmd.dec ? r_pkey[0] : r_pkey[17]);
        unique case (i_cmd.kc_sel)
            2'd0:    kc_w = r_kc0;
            2'd1:    kc_w = r_kc1;
            default: kc_w = r_kc2;
        endcase
        wa = i_cmd.addr;
        wd = r_th;
        we = 1'b0;
        unique case (i_cmd.op)
            k1bf_pkg::OP_LOAD: begin
                wa = r_idx;
                wd = r_word;
                we = (r_idx < 11'(k1bf_pkg::TableWords));
            end
            k1bf_pkg::OP_MIX: begin
                wa = {6'd0, i_cmd.idx};
                wd = p_rd ^ swap_bytes(kc_w);
                we = 1'b1;
            end
            k1bf_pkg::OP_WR_HI: begin
                wd = r_th;
                we = 1'b1;
            end
            k1bf_pkg::OP_WR_LO: begin
                wd = r_tl;
                we = 1'b1;
            end
            default: ;
        endcase
        s_off = wa - k1bf_pkg::SboxBase;
    end

    always_ff @(posedge i_clk) begin
        if (we && wa < k1bf_pkg::SboxBase) begin
            r_pkey[wa[4:0]] <= wd;
        end
        for (int b = 0; b < 4; b++) begin
            if (we && wa >= k1bf_pkg::SboxBase && s_off[9:8] == 2'(b)) begin
                r_sbox[b][s_off[7:0]] <= wd;
            end
            r_sd[b] <= r_sbox[b][sa[b]];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            k1bf_pkg::OP_CAPTURE: begin
                r_mode    <= i_mode;
                r_idx     <= i_table_index;
                r_word    <= i_table_word;
                r_blo     <= i_block_low;
                r_bhi     <= i_block_high;
                r_id      <= i_id_code;
                r_level   <= i_level;
                r_key_mod <= i_key_mod;
                r_rlo     <= '0;
                r_rhi     <= '0;
            end
            k1bf_pkg::OP_INIT_KC: begin
                r_kc0 <= r_id;
                r_kc1 <= r_id >> 1;
                r_kc2 <= r_id << 1;
            end
            k1bf_pkg::OP_INIT: begin
                unique case (i_cmd.job)
                    k1bf_pkg::JOB_BLOCK: begin r_y <= r_blo; r_x <= r_bhi; end
                    k1bf_pkg::JOB_KC12:  begin r_y <= r_kc1; r_x <= r_kc2; end
                    k1bf_pkg::JOB_KC01:  begin r_y <= r_kc0; r_x <= r_kc1; end
                    default:             begin r_y <= r_tl;  r_x <= r_th;  end
                endcase
            end
            k1bf_pkg::OP_ROUND_A: begin
                r_z <= z;
            end
            k1bf_pkg::OP_ROUND_B: begin
                r_x <= f ^ r_y;
                r_y <= r_z;
            end
            k1bf_pkg::OP_FINISH: begin
                unique case (i_cmd.job)
                    k1bf_pkg::JOB_BLOCK: begin r_rlo <= fin_lo; r_rhi <= fin_hi; end
                    k1bf_pkg::JOB_KC12:  begin r_kc1 <= fin_lo; r_kc2 <= fin_hi; end
                    k1bf_pkg::JOB_KC01:  begin r_kc0 <= fin_lo; r_kc1 <= fin_hi; end
                    default:             begin r_tl  <= fin_lo; r_th  <= fin_hi; end
                endcase
            end
            k1bf_pkg::OP_CLR_T: begin
                r_tl <= '0;
                r_th <= '0;
            end
            k1bf_pkg::OP_SHIFT: begin
                r_kc1 <= r_kc1 << 1;
                r_kc2 <= r_kc2 >> 1;
            end
            k1bf_pkg::OP_OUTLD: begin
                r_olo <= r_rlo;
                r_ohi <= r_rhi;
            end
            default: ;
        endcase
    end

    assign o_status   = '{mode: r_mode, level: r_level, key_mod: r_key_mod};
    assign o_out_low  = r_olo;
    assign o_out_high = r_ohi;

endmodule
`default_nettype wire

/* rtl/k1bf_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// k1bf_controller
// Sequencer for load, block cipher and keycode schedule items.
// ----------------------------------------------------------------------------
module k1bf_controller (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire k1bf_pkg::t_status i_status,
    output k1bf_pkg::t_cmd         o_cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DISPATCH = 4'd1;
    localparam logic [3:0] ST_INIT     = 4'd2;
    localparam logic [3:0] ST_RA       = 4'd3;
    localparam logic [3:0] ST_RB       = 4'd4;
    localparam logic [3:0] ST_FIN      = 4'd5;
    localparam logic [3:0] ST_MIX      = 4'd6;
    localparam logic [3:0] ST_CLRT     = 4'd7;
    localparam logic [3:0] ST_WRH      = 4'd8;
    localparam logic [3:0] ST_WRL      = 4'd9;
    localparam logic [3:0] ST_SHIFT    = 4'd10;
    localparam logic [3:0] ST_DONE     = 4'd11;

    logic [3:0]  r_state, n_state;
    logic [3:0]  r_rnd, n_rnd;
    logic [4:0]  r_cnt, n_cnt;
    logic [1:0]  r_mod, n_mod;
    logic [10:0] r_pair, n_pair;
    logic [1:0]  r_pass, n_pass;
    logic [1:0]  r_job, n_job;
    logic        r_ovalid, n_ovalid;
    logic [1:0]  md_eff;
    logic        accept;

    assign md_eff = (i_status.key_mod == 2'd0) ? 2'd1 : i_status.key_mod;
    assign o_in_ready = (r_state == ST_IDLE);
    assign accept = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_rnd    = r_rnd;
        n_cnt    = r_cnt;
        n_mod    = r_mod;
        n_pair   = r_pair;
        n_pass   = r_pass;
        n_job    = r_job;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '0;
        o_cmd.op = k1bf_pkg::OP_NONE;
        o_cmd.job = r_job;
        o_cmd.dec = (r_job == k1bf_pkg::JOB_BLOCK) && (i_status.mode == k1bf_pkg::MODE_DECRYPT);
        o_cmd.idx = o_cmd.dec ? (5'd17 - {1'b0, r_rnd}) : {1'b0, r_rnd};
        o_cmd.addr = r_pair;
        o_cmd.kc_sel = r_mod;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.op = k1bf_pkg::OP_CAPTURE;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_job = k1bf_pkg::JOB_BLOCK;
                n_rnd = '0;
                unique case (i_status.mode)
                    k1bf_pkg::MODE_LOAD: begin
                        o_cmd.op = k1bf_pkg::OP_LOAD;
                        n_state = ST_DONE;
                    end
                    k1bf_pkg::MODE_SCHEDULE: begin
                        o_cmd.op = k1bf_pkg::OP_INIT_KC;
                        n_job = k1bf_pkg::JOB_KC12;
                        n_pass = 2'd1;
                        n_state = (i_status.level == 2'd0) ? ST_DONE : ST_INIT;
                    end
                    default: n_state = ST_INIT;
                endcase
            end
            ST_INIT: begin
                o_cmd.op = k1bf_pkg::OP_INIT;
                n_rnd = '0;
                n_state = ST_RA;
            end
            ST_RA: begin
                o_cmd.op = k1bf_pkg::OP_ROUND_A;
                n_state = ST_RB;
            end
            ST_RB: begin
                o_cmd.op = k1bf_pkg::OP_ROUND_B;
                n_rnd = r_rnd + 4'd1;
                n_state = (r_rnd == 4'd15) ? ST_FIN : ST_RA;
            end
            ST_FIN: begin
                o_cmd.op = k1bf_pkg::OP_FINISH;
                unique case (r_job)
                    k1bf_pkg::JOB_BLOCK: n_state = ST_DONE;
                    k1bf_pkg::JOB_KC12: begin
                        n_job = k1bf_pkg::JOB_KC01;
                        n_state = ST_INIT;
                    end
                    k1bf_pkg::JOB_KC01: begin
                        n_cnt = '0;
                        n_mod = '0;
                        n_state = ST_MIX;
                    end
                    default: n_state = ST_WRH;
                endcase
            end
            ST_MIX: begin
                o_cmd.op = k1bf_pkg::OP_MIX;
                o_cmd.idx = r_cnt;
                n_cnt = r_cnt + 5'd1;
                n_mod = (r_mod + 2'd1 == md_eff) ? 2'd0 : r_mod + 2'd1;
                if (r_cnt == k1bf_pkg::LastRoundKey) begin
                    n_pair = '0;
                    n_state = ST_CLRT;
                end
            end
            ST_CLRT: begin
                o_cmd.op = k1bf_pkg::OP_CLR_T;
                n_job = k1bf_pkg::JOB_T;
                n_state = ST_INIT;
            end
            ST_WRH: begin
                o_cmd.op = k1bf_pkg::OP_WR_HI;
                n_state = ST_WRL;
            end
            ST_WRL: begin
                o_cmd.op = k1bf_pkg::OP_WR_LO;
                o_cmd.addr = r_pair + 11'd1;
                if (r_pair == k1bf_pkg::LastPair) begin
                    if (r_pass < i_status.level) begin
                        n_pass = r_pass + 2'd1;
                        n_job = k1bf_pkg::JOB_KC12;
                        n_state = (r_pass == 2'd2) ? ST_SHIFT : ST_INIT;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    n_pair = r_pair + 11'd2;
                    n_state = ST_INIT;
                end
            end
            ST_SHIFT: begin
                o_cmd.op = k1bf_pkg::OP_SHIFT;
                n_state = ST_INIT;
            end
            ST_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.op = k1bf_pkg::OP_OUTLD;
                    n_ovalid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rnd    <= '0;
            r_cnt    <= '0;
            r_mod    <= '0;
            r_pair   <= '0;
            r_pass   <= '0;
            r_job    <= k1bf_pkg::JOB_BLOCK;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rnd    <= n_rnd;
            r_cnt    <= n_cnt;
            r_mod    <= n_mod;
            r_pair   <= n_pair;
            r_pass   <= n_pass;
            r_job    <= n_job;
            r_ovalid <= n_ovalid;
        end
    end

`ifndef SYNTH
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_DISPATCH)
        else $error("accepted item did not reach dispatch");
    a_mix_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MIX |-> r_mod < md_eff)
        else $error("keycode select beyond modulus");
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == ST_DONE)
        else $error("result raised outside completion");
    a_pair_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WRH |-> r_pair[0] == 1'b0 && r_pair <= k1bf_pkg::LastPair)
        else $error("table pair address out of sequence");
`endif

endmodule
`default_nettype wire

/* rtl/key1_blowfish_cipher_engine_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// An encrypt or decrypt item runs each round as an ST_RA step and then an ST_RB step
// through the registered S-box read ports.
// A keycode item runs 523 block encryptions per pass.
// One item is processed at a time; the next is taken while a result waits.
// Reset (synchronous, active low) clears control state; the key table is not cleared.
// ----------------------------------------------------------------------------
// key1_blowfish_cipher_engine_unit
// Blowfish-style 64-bit cipher engine with a loadable 1042-word key table.
// ----------------------------------------------------------------------------
module key1_blowfish_cipher_engine_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // table_index[10:0], table_word[42:11], block_low[74:43], block_high[106:75],
    // id_code[138:107], level[140:139], key_mod[142:141], zero[143]
    input  wire logic [143:0] s_axis_tdata,
    // mode[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_low[31:0], out_high[63:32]
    output logic [63:0]       m_axis_tdata
);

    k1bf_pkg::t_cmd    cmd;
    k1bf_pkg::t_status status;
    logic [31:0]       out_low, out_high;

    k1bf_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    k1bf_datapath u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_mode        (s_axis_tuser),
        .i_table_index (s_axis_tdata[10:0]),
        .i_table_word  (s_axis_tdata[42:11]),
        .i_block_low   (s_axis_tdata[74:43]),
        .i_block_high  (s_axis_tdata[106:75]),
        .i_id_code     (s_axis_tdata[138:107]),
        .i_level       (s_axis_tdata[140:139]),
        .i_key_mod     (s_axis_tdata[142:141]),
        .o_status      (status),
        .o_out_low     (out_low),
        .o_out_high    (out_high)
    );

    assign m_axis_tdata = {out_high, out_low};

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// KEY1 cipher engine testbench
// Loads the whole key table, then drives directed and random load, encrypt,
// decrypt and keycode schedule items with random gaps and output stalls, and
// compares every result with a cycle-free model of the cipher held below.
// ----------------------------------------------------------------------------
import k1bf_pkg::*;

class key1_scoreboard;
    bit [31:0] key_words [TableWords];
    bit [63:0] expected_blocks [$];
    int errors;

    function bit [31:0] sbox_mix(bit [31:0] z);
        bit [31:0] f;
        f = key_words[SboxBase + z[31:24]];
        f += key_words[SboxBase + 256 + z[23:16]];
        f ^= key_words[SboxBase + 512 + z[15:8]];
        f += key_words[SboxBase + 768 + z[7:0]];
        return f;
    endfunction

    function void run_cipher(inout bit [31:0] lo, inout bit [31:0] hi, input bit decrypt);
        bit [31:0] y, x, z;
        int r;
        y = lo;
        x = hi;
        for (int n = 0; n < 16; n++) begin
            r = decrypt ? 17 - n : n;
            z = key_words[r] ^ x;
            x = sbox_mix(z) ^ y;
            y = z;
        end
        lo = x ^ key_words[decrypt ? 1 : 16];
        hi = y ^ key_words[decrypt ? 0 : 17];
    endfunction

    function void keycode_pass(inout bit [31:0] kc [3], input int modulus);
        bit [31:0] tl, th, w;
        tl = 0;
        th = 0;
        run_cipher(kc[1], kc[2], 1'b0);
        run_cipher(kc[0], kc[1], 1'b0);
        for (int i = 0; i <= LastRoundKey; i++) begin
            w = kc[i % modulus];
            key_words[i] ^= {w[7:0], w[15:8], w[23:16], w[31:24]};
        end
        for (int i = 0; i <= LastPair; i += 2) begin
            run_cipher(tl, th, 1'b0);
            key_words[i] = th;
            key_words[i + 1] = tl;
        end
    endfunction

    function void note_input(bit [1:0] mode, bit [143:0] data);
        bit [31:0] lo, hi, id;
        bit [31:0] kc [3];
        bit [10:0] idx;
        bit [1:0] level;
        int modulus;
        idx = data[10:0];
        lo = data[74:43];
        hi = data[106:75];
        id = data[138:107];
        level = data[140:139];
        modulus = (data[142:141] == 0) ? 1 : data[142:141];
        case (mode)
            MODE_LOAD: begin
                if (idx < TableWords) key_words[idx] = data[42:11];
                lo = 0;
                hi = 0;
            end
            MODE_ENCRYPT: run_cipher(lo, hi, 1'b0);
            MODE_DECRYPT: run_cipher(lo, hi, 1'b1);
            default: begin
                kc[0] = id;
                kc[1] = id >> 1;
                kc[2] = id << 1;
                if (level >= 1) keycode_pass(kc, modulus);
                if (level >= 2) keycode_pass(kc, modulus);
                if (level >= 3) begin
                    kc[1] = kc[1] << 1;
                    kc[2] = kc[2] >> 1;
                    keycode_pass(kc, modulus);
                end
                lo = 0;
                hi = 0;
            end
        endcase
        expected_blocks.push_back({hi, lo});
    endfunction

    function void check_result(bit [63:0] actual);
        bit [63:0] want;
        if (expected_blocks.size() == 0) begin
            $display("%0t: unexpected result %h", $time, actual);
            errors++;
            return;
        end
        want = expected_blocks.pop_front();
        if (want[31:0] !== actual[31:0]) begin
            $display("%0t: out_low expected %h actual %h", $time, want[31:0], actual[31:0]);
            errors++;
        end
        if (want[63:32] !== actual[63:32]) begin
            $display("%0t: out_high expected %h actual %h", $time, want[63:32],
                     actual[63:32]);
            errors++;
        end
    endfunction

    function int pending();
        return expected_blocks.size();
    endfunction
endclass

module testbench;
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;

    key1_scoreboard board;
    int sent_count = 0;
    int result_count = 0;
    int passes_left = 18;

    key1_blowfish_cipher_engine_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit [143:0] pack_item(bit [10:0] idx, bit [31:0] word, bit [31:0] lo,
                                             bit [31:0] hi, bit [31:0] id, bit [1:0] level,
                                             bit [1:0] key_mod);
        return {1'b0, key_mod, level, id, hi, lo, word, idx};
    endfunction

    task automatic send_item(bit [1:0] mode, bit [143:0] data);
        int gap;
        s_axis_tuser <= mode;
        s_axis_tdata <= data;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_input(mode, data);
        sent_count++;
        gap = ((sent_count % 300) < 60) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_load(bit [10:0] idx, bit [31:0] word);
        send_item(MODE_LOAD, pack_item(idx, word, $urandom, $urandom, $urandom,
                                       $urandom, $urandom));
    endtask

    task automatic send_block(bit [1:0] mode, bit [31:0] lo, bit [31:0] hi);
        send_item(mode, pack_item($urandom, $urandom, lo, hi, $urandom, $urandom, $urandom));
    endtask

    task automatic send_schedule(bit [31:0] id, bit [1:0] level, bit [1:0] key_mod);
        send_item(MODE_SCHEDULE, pack_item($urandom, $urandom, $urandom, $urandom, id,
                                           level, key_mod));
    endtask

    initial begin
        int pick;
        bit [1:0] level;
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < TableWords; i++) begin
            send_load(i, (i == 0) ? 32'h0 : (i == TableWords - 1) ? 32'hFFFF_FFFF : $urandom);
        end
        send_block(MODE_ENCRYPT, 32'h0, 32'h0);
        send_block(MODE_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(MODE_DECRYPT, 32'h0, 32'h0);
        send_block(MODE_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_load(11'd1042, 32'hDEAD_BEEF);
        send_load(11'h7FF, 32'hFFFF_FFFF);
        send_block(MODE_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
        send_schedule(32'hFFFF_FFFF, 2'd0, 2'd1);
        send_block(MODE_ENCRYPT, 32'h0, 32'h0);
        send_schedule(32'h0, 2'd1, 2'd1);
        send_block(MODE_DECRYPT, 32'h5555_AAAA, 32'hAAAA_5555);
        send_schedule(32'hFFFF_FFFF, 2'd2, 2'd2);
        send_block(MODE_ENCRYPT, 32'h1, 32'h8000_0000);
        send_schedule($urandom, 2'd3, 2'd3);
        send_schedule($urandom, 2'd1, 2'd0);
        send_block(MODE_DECRYPT, 32'hFFFF_FFFF, 32'h0);

        for (int n = 0; n < 950; n++) begin
            pick = $urandom_range(0, 999);
            if (pick < 450) begin
                send_block(MODE_ENCRYPT, $urandom, $urandom);
            end else if (pick < 900) begin
                send_block(MODE_DECRYPT, $urandom, $urandom);
            end else if (pick < 990) begin
                send_load($urandom_range(0, 2047), $urandom);
            end else begin
                level = $urandom_range(0, 3);
                if (level > passes_left) level = 0;
                passes_left -= level;
                send_schedule($urandom, level, $urandom_range(0, 3));
            end
        end
        s_axis_tvalid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            board.check_result(m_axis_tdata);
            result_count++;
            if (result_count == 1100) begin
                stall = 400;
            end else begin
                stall = ((result_count % 250) < 50) ? 0 : $urandom_range(0, 17);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

/* sim.f */
rtl/k1bf_pkg.sv
rtl/k1bf_datapath.sv
rtl/k1bf_controller.sv
rtl/key1_blowfish_cipher_engine_unit.sv
tb/testbench.sv
